// File: rtl/pjr_pkg.sv
// Shared types, constants and helpers of the pivot joint rotation block.
// No dependencies; every other file refers to it by scoped names.
package pjr_pkg;

   localparam int CHILD_SLOTS  = 8;
   localparam int SLOT_W       = $clog2(CHILD_SLOTS);
   localparam int ANG_W        = 19;
   localparam int TRIG_W       = 20;
   localparam int ROT_W        = 36;
   localparam int SUM_W        = 38;
   localparam int MAC_W        = ROT_W + TRIG_W + 1;
   localparam int WRAP_W       = 36;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = 4;
   localparam int WRAP_K_W     = 5;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ROT_W-1:0]  rot_type;
   typedef logic signed [31:0]       q_type;
   typedef logic [ANG_W-1:0]         ang_type;

   localparam trig_type TWO_PI_S    = 20'sd411775;
   localparam trig_type PI_S        = 20'sd205887;
   localparam trig_type HALF_PI_S   = 20'sd102944;
   localparam trig_type CORDIC_GAIN = 20'sd39797;

   localparam logic [WRAP_W-1:0]   TWO_PI_W    = 36'd411775;
   localparam logic [WRAP_W-1:0]   WRAP_OFFSET = 36'd13493043200;
   localparam logic [WRAP_K_W-1:0] WRAP_K_TOP  = 5'd16;

   localparam logic [1:0] MODE_ATTACH = 2'd0;
   localparam logic [1:0] MODE_PIVOT  = 2'd1;
   localparam logic [1:0] MODE_MOVE   = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic KIND_PIVOT = 1'b0;
   localparam logic KIND_CHILD = 1'b1;

   localparam logic [1:0] CSR_PIVOT_X = 2'd0;
   localparam logic [1:0] CSR_PIVOT_Y = 2'd1;
   localparam logic [1:0] CSR_PIVOT_Z = 2'd2;

   function automatic trig_type atan_at(input logic [STEP_W-1:0] i);
      trig_type r;
      unique case (i)
         4'd0:    r = 20'sd51472;
         4'd1:    r = 20'sd30386;
         4'd2:    r = 20'sd16055;
         4'd3:    r = 20'sd8150;
         4'd4:    r = 20'sd4091;
         4'd5:    r = 20'sd2047;
         4'd6:    r = 20'sd1024;
         4'd7:    r = 20'sd512;
         4'd8:    r = 20'sd256;
         4'd9:    r = 20'sd128;
         4'd10:   r = 20'sd64;
         4'd11:   r = 20'sd32;
         4'd12:   r = 20'sd16;
         4'd13:   r = 20'sd8;
         4'd14:   r = 20'sd4;
         default: r = 20'sd2;
      endcase
      return r;
   endfunction

   function automatic q_type sat32(input logic signed [SUM_W-1:0] v);
      q_type r;
      if (v > 38'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -38'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/pivot_joint_point_rotation_top.sv
// Pivot joint top level: slot state, sequencer and output register.
// Instantiates pjr_wrap, pjr_cordic and pjr_rot; uses pjr_pkg.
//
//   channel  ports                          direction
//   req      req_valid/req_ready + fields   in
//   rsp      rsp_valid/rsp_ready + fields   out
//   csr      csr_we/csr_index/csr_wdata     in, write only
//
// Attach, ignored modes and out-of-range slots finish in idle and give no response.
// Pivot update and child move run from accept to rsp_valid through two angle
// reductions, two CORDIC runs, the multiplier and the output register load; a new
// item is accepted only when the sequencer is back in idle.
// Reset clears control, pivot angles and the rotated pivot; slots hold until attach.
// A stalled rsp holds the result; the next item may start and waits in its last state.
module pivot_joint_point_rotation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_child_index,
   input  logic signed [31:0] req_father_pos_x,
   input  logic signed [31:0] req_father_pos_y,
   input  logic signed [31:0] req_father_pos_z,
   input  logic signed [31:0] req_father_rot_x,
   input  logic signed [31:0] req_father_rot_y,
   input  logic signed [31:0] req_child_pos_x,
   input  logic signed [31:0] req_child_pos_y,
   input  logic signed [31:0] req_child_pos_z,
   input  logic signed [31:0] req_child_rot_x,
   input  logic signed [31:0] req_child_rot_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WX   = 4'd1;
   localparam logic [3:0] S_WXW  = 4'd2;
   localparam logic [3:0] S_WY   = 4'd3;
   localparam logic [3:0] S_WYW  = 4'd4;
   localparam logic [3:0] S_CX   = 4'd5;
   localparam logic [3:0] S_CXW  = 4'd6;
   localparam logic [3:0] S_CY   = 4'd7;
   localparam logic [3:0] S_CYW  = 4'd8;
   localparam logic [3:0] S_ROT  = 4'd9;
   localparam logic [3:0] S_ROTW = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   localparam int SW = pjr_pkg::SLOT_W;

   logic [3:0]              state_ff;
   pjr_pkg::q_type          pivot_ff [3];
   pjr_pkg::q_type          rpivot_ff [3];
   pjr_pkg::ang_type        pang_x_ff, pang_y_ff;
   pjr_pkg::q_type          lfr_x_ff, lfr_y_ff;
   pjr_pkg::q_type          offset_ff [pjr_pkg::CHILD_SLOTS][3];
   pjr_pkg::ang_type        csum_ff [pjr_pkg::CHILD_SLOTS][2];
   pjr_pkg::q_type          lcr_ff [pjr_pkg::CHILD_SLOTS][2];

   logic                    move_ff;
   logic [SW-1:0]           slot_ff;
   pjr_pkg::q_type          fp_ff [3];
   pjr_pkg::q_type          vec_ff [3];
   pjr_pkg::ang_type        acc_x_ff, acc_y_ff, ang_x_ff, ang_y_ff;
   pjr_pkg::q_type          now_x_ff, now_y_ff, old_x_ff, old_y_ff;
   pjr_pkg::trig_type       sx_ff, cx_ff;

   logic                    rsp_valid_ff;
   logic                    kind_ff;
   pjr_pkg::q_type          out_ff [3];

   logic                    accept;
   logic                    slot_ok;
   logic [SW-1:0]           slot;
   logic                    wrap_start, wrap_done;
   pjr_pkg::ang_type        wrap_acc, wrap_angle;
   pjr_pkg::q_type          wrap_now, wrap_old;
   logic                    cor_start, cor_done;
   pjr_pkg::ang_type        cor_angle;
   pjr_pkg::trig_type       cor_sin, cor_cos;
   logic                    rot_done;
   pjr_pkg::rot_type        rot_r [3];
   logic                    out_free;
   pjr_pkg::q_type          res [3];
   pjr_pkg::q_type          cp [3];
   pjr_pkg::q_type          fp_in [3];

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign slot       = req_child_index[SW-1:0];
   assign slot_ok    = (32'(req_child_index) < pjr_pkg::CHILD_SLOTS);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cp[0]      = req_child_pos_x;
   assign cp[1]      = req_child_pos_y;
   assign cp[2]      = req_child_pos_z;
   assign fp_in[0]   = req_father_pos_x;
   assign fp_in[1]   = req_father_pos_y;
   assign fp_in[2]   = req_father_pos_z;

   assign wrap_start = (state_ff == S_WX) || (state_ff == S_WY);
   assign wrap_acc   = (state_ff == S_WX) ? acc_x_ff : acc_y_ff;
   assign wrap_now   = (state_ff == S_WX) ? now_x_ff : now_y_ff;
   assign wrap_old   = (state_ff == S_WX) ? old_x_ff : old_y_ff;
   assign cor_start  = (state_ff == S_CX) || (state_ff == S_CY);
   assign cor_angle  = (state_ff == S_CX) ? ang_x_ff : ang_y_ff;

   pjr_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .start     (wrap_start),
      .acc_in    (wrap_acc),
      .now_in    (wrap_now),
      .old_in    (wrap_old),
      .done      (wrap_done),
      .angle_out (wrap_angle)
   );

   pjr_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (cor_start),
      .angle_in (cor_angle),
      .done     (cor_done),
      .sin_out  (cor_sin),
      .cos_out  (cor_cos)
   );

   pjr_rot u_rot (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_ROT),
      .sin_x (sx_ff),
      .cos_x (cx_ff),
      .sin_y (cor_sin),
      .cos_y (cor_cos),
      .v0    (vec_ff[0]),
      .v1    (vec_ff[1]),
      .v2    (vec_ff[2]),
      .done  (rot_done),
      .r0    (rot_r[0]),
      .r1    (rot_r[1]),
      .r2    (rot_r[2])
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (move_ff) begin
            res[i] = pjr_pkg::sat32(pjr_pkg::SUM_W'(fp_ff[i]) + pjr_pkg::SUM_W'(rot_r[i])
                                    + pjr_pkg::SUM_W'(rpivot_ff[i]));
         end else begin
            res[i] = pjr_pkg::sat32(pjr_pkg::SUM_W'(rot_r[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pang_x_ff    <= '0;
         pang_y_ff    <= '0;
         lfr_x_ff     <= '0;
         lfr_y_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            pivot_ff[i]  <= '0;
            rpivot_ff[i] <= '0;
         end
      end else begin
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               pjr_pkg::CSR_PIVOT_X: pivot_ff[0] <= csr_wdata;
               pjr_pkg::CSR_PIVOT_Y: pivot_ff[1] <= csr_wdata;
               pjr_pkg::CSR_PIVOT_Z: pivot_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  fp_ff[0] <= req_father_pos_x;
                  fp_ff[1] <= req_father_pos_y;
                  fp_ff[2] <= req_father_pos_z;
                  slot_ff  <= slot;
                  priority if (req_mode == pjr_pkg::MODE_ATTACH && slot_ok) begin
                     for (int i = 0; i < 3; i++) begin
                        offset_ff[slot][i] <= pjr_pkg::sat32(pjr_pkg::SUM_W'(cp[i])
                           - pjr_pkg::SUM_W'(fp_in[i])
                           - pjr_pkg::SUM_W'(pivot_ff[i]));
                        rpivot_ff[i] <= pivot_ff[i];
                     end
                     csum_ff[slot][0] <= '0;
                     csum_ff[slot][1] <= '0;
                     lcr_ff[slot][0]  <= req_child_rot_x;
                     lcr_ff[slot][1]  <= req_child_rot_y;
                     pang_x_ff        <= '0;
                     pang_y_ff        <= '0;
                     lfr_x_ff         <= req_father_rot_x;
                     lfr_y_ff         <= req_father_rot_y;
                  end else if (req_mode == pjr_pkg::MODE_PIVOT) begin
                     move_ff  <= 1'b0;
                     acc_x_ff <= pang_x_ff;
                     acc_y_ff <= pang_y_ff;
                     now_x_ff <= req_father_rot_x;
                     now_y_ff <= req_father_rot_y;
                     old_x_ff <= lfr_x_ff;
                     old_y_ff <= lfr_y_ff;
                     lfr_x_ff <= req_father_rot_x;
                     lfr_y_ff <= req_father_rot_y;
                     for (int i = 0; i < 3; i++) begin
                        vec_ff[i] <= pivot_ff[i];
                     end
                     state_ff <= S_WX;
                  end else if (req_mode == pjr_pkg::MODE_MOVE && slot_ok) begin
                     move_ff  <= 1'b1;
                     acc_x_ff <= csum_ff[slot][0];
                     acc_y_ff <= csum_ff[slot][1];
                     now_x_ff <= req_child_rot_x;
                     now_y_ff <= req_child_rot_y;
                     old_x_ff <= lcr_ff[slot][0];
                     old_y_ff <= lcr_ff[slot][1];
                     lcr_ff[slot][0] <= req_child_rot_x;
                     lcr_ff[slot][1] <= req_child_rot_y;
                     for (int i = 0; i < 3; i++) begin
                        vec_ff[i] <= offset_ff[slot][i];
                     end
                     state_ff <= S_WX;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_WX: state_ff <= S_WXW;
            S_WXW: begin
               if (wrap_done) begin
                  ang_x_ff <= wrap_angle;
                  if (move_ff) csum_ff[slot_ff][0] <= wrap_angle;
                  else         pang_x_ff <= wrap_angle;
                  state_ff <= S_WY;
               end
            end
            S_WY: state_ff <= S_WYW;
            S_WYW: begin
               if (wrap_done) begin
                  ang_y_ff <= wrap_angle;
                  if (move_ff) csum_ff[slot_ff][1] <= wrap_angle;
                  else         pang_y_ff <= wrap_angle;
                  state_ff <= S_CX;
               end
            end
            S_CX: state_ff <= S_CXW;
            S_CXW: begin
               if (cor_done) begin
                  sx_ff    <= cor_sin;
                  cx_ff    <= cor_cos;
                  state_ff <= S_CY;
               end
            end
            S_CY: state_ff <= S_CYW;
            S_CYW: begin
               if (cor_done) begin
                  state_ff <= S_ROT;
               end
            end
            S_ROT: state_ff <= S_ROTW;
            S_ROTW: begin
               if (rot_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  kind_ff      <= move_ff ? pjr_pkg::KIND_CHILD : pjr_pkg::KIND_PIVOT;
                  for (int i = 0; i < 3; i++) begin
                     out_ff[i] <= res[i];
                     if (!move_ff) rpivot_ff[i] <= res[i];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_x       = out_ff[0];
   assign rsp_out_y       = out_ff[1];
   assign rsp_out_z       = out_ff[2];

endmodule

// File: rtl/pjr_wrap.sv
// Angle accumulator update: acc + now - old reduced into [0, 2*pi).
// One conditional subtract of a shifted 2*pi per cycle; uses pjr_pkg.
module pjr_wrap (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  pjr_pkg::ang_type acc_in,
   input  pjr_pkg::q_type  now_in,
   input  pjr_pkg::q_type  old_in,
   output logic            done,
   output pjr_pkg::ang_type angle_out
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [pjr_pkg::WRAP_K_W-1:0]  k_ff;
   logic [pjr_pkg::WRAP_W-1:0]    r_ff;
   logic [pjr_pkg::WRAP_W:0]      init;
   logic [pjr_pkg::WRAP_W-1:0]    lim;

   assign init = (pjr_pkg::WRAP_W+1)'($signed({1'b0, acc_in}))
               + (pjr_pkg::WRAP_W+1)'(now_in)
               - (pjr_pkg::WRAP_W+1)'(old_in)
               + (pjr_pkg::WRAP_W+1)'(pjr_pkg::WRAP_OFFSET);
   assign lim  = pjr_pkg::TWO_PI_W << k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= pjr_pkg::WRAP_K_TOP;
            r_ff    <= init[pjr_pkg::WRAP_W-1:0];
         end else if (busy_ff) begin
            if (r_ff >= lim) begin
               r_ff <= r_ff - lim;
            end
            k_ff <= k_ff - 1'b1;
            if (k_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign angle_out = r_ff[pjr_pkg::ANG_W-1:0];

endmodule

// File: rtl/pjr_cordic.sv
// Iterative CORDIC sine/cosine: quadrant fold, then one rotation step a cycle.
// Uses pjr_pkg for the arctangent table and fixed-point constants.
module pjr_cordic (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pjr_pkg::ang_type angle_in,
   output logic             done,
   output pjr_pkg::trig_type sin_out,
   output pjr_pkg::trig_type cos_out
);

   logic                        busy_ff;
   logic                        done_ff;
   logic                        neg_ff;
   logic [pjr_pkg::STEP_W-1:0]  i_ff;
   pjr_pkg::trig_type           x_ff;
   pjr_pkg::trig_type           y_ff;
   pjr_pkg::trig_type           z_ff;
   pjr_pkg::trig_type           a0;
   pjr_pkg::trig_type           a1;
   pjr_pkg::trig_type           a2;
   logic                        neg_in;
   pjr_pkg::trig_type           dx;
   pjr_pkg::trig_type           dy;
   pjr_pkg::trig_type           at;

   always_comb begin
      a0     = $signed({1'b0, angle_in});
      a1     = (a0 > pjr_pkg::PI_S) ? a0 - pjr_pkg::TWO_PI_S : a0;
      a2     = a1;
      neg_in = 1'b0;
      if (a1 > pjr_pkg::HALF_PI_S) begin
         a2     = a1 - pjr_pkg::PI_S;
         neg_in = 1'b1;
      end else if (a1 < -pjr_pkg::HALF_PI_S) begin
         a2     = a1 + pjr_pkg::PI_S;
         neg_in = 1'b1;
      end
   end

   assign dx = y_ff >>> i_ff;
   assign dy = x_ff >>> i_ff;
   assign at = pjr_pkg::atan_at(i_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            i_ff    <= '0;
            x_ff    <= pjr_pkg::CORDIC_GAIN;
            y_ff    <= '0;
            z_ff    <= a2;
            neg_ff  <= neg_in;
         end else if (busy_ff) begin
            if (!z_ff[pjr_pkg::TRIG_W-1]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            i_ff <= i_ff + 1'b1;
            if (i_ff == pjr_pkg::STEP_W'(pjr_pkg::CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;

endmodule

// File: rtl/pjr_rot.sv
// Ry*Rx rotation of a vector on one shared multiplier and accumulator.
// Eight products, one a cycle, product registered; uses pjr_pkg.
module pjr_rot (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pjr_pkg::trig_type sin_x,
   input  pjr_pkg::trig_type cos_x,
   input  pjr_pkg::trig_type sin_y,
   input  pjr_pkg::trig_type cos_y,
   input  pjr_pkg::q_type    v0,
   input  pjr_pkg::q_type    v1,
   input  pjr_pkg::q_type    v2,
   output logic              done,
   output pjr_pkg::rot_type  r0,
   output pjr_pkg::rot_type  r1,
   output pjr_pkg::rot_type  r2
);

   logic                                   busy_ff;
   logic                                   done_ff;
   logic [3:0]                             cnt_ff;
   pjr_pkg::trig_type                      sx_ff, cx_ff, sy_ff, cy_ff;
   pjr_pkg::q_type                         v0_ff, v1_ff, v2_ff;
   pjr_pkg::rot_type                       y1_ff, z1_ff, r0_ff, r2_ff;
   logic signed [pjr_pkg::MAC_W-2:0]       prod_ff;
   logic signed [pjr_pkg::MAC_W-1:0]       acc_ff;
   pjr_pkg::trig_type                      a_mux;
   pjr_pkg::rot_type                       b_mux;
   logic [3:0]                             kk;
   logic signed [pjr_pkg::MAC_W-1:0]       sum;
   pjr_pkg::rot_type                       res;

   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0: begin a_mux = cx_ff; b_mux = pjr_pkg::ROT_W'(v1_ff); end
         3'd1: begin a_mux = sx_ff; b_mux = pjr_pkg::ROT_W'(v2_ff); end
         3'd2: begin a_mux = sx_ff; b_mux = pjr_pkg::ROT_W'(v1_ff); end
         3'd3: begin a_mux = cx_ff; b_mux = pjr_pkg::ROT_W'(v2_ff); end
         3'd4: begin a_mux = cy_ff; b_mux = pjr_pkg::ROT_W'(v0_ff); end
         3'd5: begin a_mux = sy_ff; b_mux = z1_ff; end
         3'd6: begin a_mux = sy_ff; b_mux = pjr_pkg::ROT_W'(v0_ff); end
         default: begin a_mux = cy_ff; b_mux = z1_ff; end
      endcase
   end

   assign kk  = cnt_ff - 4'd1;
   assign sum = kk[1] ? acc_ff + pjr_pkg::MAC_W'(prod_ff) : acc_ff - pjr_pkg::MAC_W'(prod_ff);
   assign res = sum[pjr_pkg::ROT_W+15:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            sx_ff   <= sin_x;
            cx_ff   <= cos_x;
            sy_ff   <= sin_y;
            cy_ff   <= cos_y;
            v0_ff   <= v0;
            v1_ff   <= v1;
            v2_ff   <= v2;
         end else if (busy_ff) begin
            prod_ff <= a_mux * b_mux;
            if (cnt_ff != 4'd0) begin
               if (!kk[0]) begin
                  acc_ff <= pjr_pkg::MAC_W'(prod_ff);
               end else begin
                  unique case (kk[2:1])
                     2'd0:    y1_ff <= res;
                     2'd1:    z1_ff <= res;
                     2'd2:    r0_ff <= res;
                     default: r2_ff <= res;
                  endcase
               end
            end
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign r0   = r0_ff;
   assign r1   = y1_ff;
   assign r2   = r2_ff;

endmodule

// File: tb/sv/tb_pivot_joint_point_rotation_top.sv
// Self-checking testbench for pivot_joint_point_rotation_top: drives attach, pivot,
// move and ignored-mode items, predicts each rotated pivot and child position, and
// compares results. Depends on pjr_pkg and the RTL of pivot_joint_point_rotation_top.
`timescale 1ns / 100ps

module tb_pivot_joint_point_rotation_top;

   localparam longint ANG_PERIOD = 411775;
   localparam longint ANG_PI     = 205887;
   localparam longint ANG_HALF   = 102944;
   localparam int     CYCLE_CAP  = 1200000;

   typedef struct {
      logic [1:0]  mode;
      logic [2:0]  slot;
      logic [31:0] fpx, fpy, fpz, frx, fry, cpx, cpy, cpz, crx, cry;
   } joint_item_type;

   typedef struct {
      logic        kind;
      logic [31:0] x, y, z;
   } joint_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = '0;
   logic [2:0] req_child_index = '0;
   logic signed [31:0] req_father_pos_x = '0, req_father_pos_y = '0, req_father_pos_z = '0;
   logic signed [31:0] req_father_rot_x = '0, req_father_rot_y = '0;
   logic signed [31:0] req_child_pos_x = '0, req_child_pos_y = '0, req_child_pos_z = '0;
   logic signed [31:0] req_child_rot_x = '0, req_child_rot_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_result_kind;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   joint_item_type   pending_items[$];
   joint_result_type expected_results[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   bit  quiet_phase = 1'b0;
   bit  attached[8];

   longint pivot_cfg[3];
   longint pivot_ang_x, pivot_ang_y, last_frx, last_fry;
   longint rot_pivot[3];
   longint slot_offset[24];
   longint slot_ang[16];
   longint slot_last[16];

   pivot_joint_point_rotation_top u_top (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap_turn(longint acc, longint now, longint old);
      longint r;
      r = (acc + now - old) % ANG_PERIOD;
      if (r < 0) r += ANG_PERIOD;
      return r;
   endfunction

   function automatic void cordic_sin_cos(longint a, output longint s, output longint c);
      longint atans[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
      bit     flip;
      longint x, y, z, dx, dy;
      flip = 1'b0;
      x = 39797;
      y = 0;
      if (a > ANG_PI) a -= ANG_PERIOD;
      if (a > ANG_HALF) begin
         a -= ANG_PI;
         flip = 1'b1;
      end else if (a < -ANG_HALF) begin
         a += ANG_PI;
         flip = 1'b1;
      end
      z = a;
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atans[i];
         end else begin
            x += dx; y -= dy; z += atans[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic void rotate_yx(longint ax, longint ay, longint v0, longint v1,
                                     longint v2, output longint r0, output longint r1,
                                     output longint r2);
      longint sa, ca, sb, cb, z1;
      cordic_sin_cos(ax, sa, ca);
      cordic_sin_cos(ay, sb, cb);
      r1 = floor_shift(ca * v1 - sa * v2, 16);
      z1 = floor_shift(sa * v1 + ca * v2, 16);
      r0 = floor_shift(cb * v0 - sb * z1, 16);
      r2 = floor_shift(sb * v0 + cb * z1, 16);
   endfunction

   function automatic void predict_joint(joint_item_type it);
      longint fp[3], cp[3], r[3];
      int s;
      joint_result_type e;
      fp = '{longint'(signed'(it.fpx)), longint'(signed'(it.fpy)), longint'(signed'(it.fpz))};
      cp = '{longint'(signed'(it.cpx)), longint'(signed'(it.cpy)), longint'(signed'(it.cpz))};
      s = it.slot;
      if (it.mode == pjr_pkg::MODE_ATTACH) begin
         for (int i = 0; i < 3; i++) begin
            slot_offset[s*3+i] = clip32(cp[i] - fp[i] - pivot_cfg[i]);
            rot_pivot[i] = pivot_cfg[i];
         end
         slot_ang[s*2] = 0;
         slot_ang[s*2+1] = 0;
         slot_last[s*2] = signed'(it.crx);
         slot_last[s*2+1] = signed'(it.cry);
         pivot_ang_x = 0;
         pivot_ang_y = 0;
         last_frx = signed'(it.frx);
         last_fry = signed'(it.fry);
      end else if (it.mode == pjr_pkg::MODE_PIVOT) begin
         pivot_ang_x = wrap_turn(pivot_ang_x, signed'(it.frx), last_frx);
         pivot_ang_y = wrap_turn(pivot_ang_y, signed'(it.fry), last_fry);
         last_frx = signed'(it.frx);
         last_fry = signed'(it.fry);
         rotate_yx(pivot_ang_x, pivot_ang_y, pivot_cfg[0], pivot_cfg[1], pivot_cfg[2],
                   r[0], r[1], r[2]);
         for (int i = 0; i < 3; i++) rot_pivot[i] = clip32(r[i]);
         e.kind = pjr_pkg::KIND_PIVOT;
         e.x = 32'(rot_pivot[0]);
         e.y = 32'(rot_pivot[1]);
         e.z = 32'(rot_pivot[2]);
         expected_results = {expected_results, e};
      end else if (it.mode == pjr_pkg::MODE_MOVE) begin
         slot_ang[s*2] = wrap_turn(slot_ang[s*2], signed'(it.crx), slot_last[s*2]);
         slot_ang[s*2+1] = wrap_turn(slot_ang[s*2+1], signed'(it.cry), slot_last[s*2+1]);
         slot_last[s*2] = signed'(it.crx);
         slot_last[s*2+1] = signed'(it.cry);
         rotate_yx(slot_ang[s*2], slot_ang[s*2+1], slot_offset[s*3], slot_offset[s*3+1],
                   slot_offset[s*3+2], r[0], r[1], r[2]);
         e.kind = pjr_pkg::KIND_CHILD;
         e.x = 32'(clip32(fp[0] + r[0] + rot_pivot[0]));
         e.y = 32'(clip32(fp[1] + r[1] + rot_pivot[1]));
         e.z = 32'(clip32(fp[2] + r[2] + rot_pivot[2]));
         expected_results = {expected_results, e};
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 131072) - 65536;
         3: return $urandom_range(0, 1 << 22) - (1 << 21);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 823550) - 411775;
         default: return $urandom_range(0, 20000) - 10000;
      endcase
   endfunction

   function automatic joint_item_type make_item(logic [1:0] m, logic [2:0] s);
      joint_item_type it;
      it.mode = m;
      it.slot = s;
      it.fpx = rand_q(); it.fpy = rand_q(); it.fpz = rand_q();
      it.frx = rand_angle(); it.fry = rand_angle();
      it.cpx = rand_q(); it.cpy = rand_q(); it.cpz = rand_q();
      it.crx = rand_angle(); it.cry = rand_angle();
      return it;
   endfunction

   // turn a move on an unattached slot into an attach, so no item reads an unattached slot
   function automatic void queue_item(joint_item_type it);
      if (it.mode == pjr_pkg::MODE_MOVE && !attached[it.slot]) it.mode = pjr_pkg::MODE_ATTACH;
      if (it.mode == pjr_pkg::MODE_ATTACH) attached[it.slot] = 1'b1;
      pending_items = {pending_items, it};
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) predict_joint(pending_items.pop_front());
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            req_gap <= $urandom_range(1, 17) - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_valid <= 1'b1;
            req_mode <= pending_items[0].mode;
            req_child_index <= pending_items[0].slot;
            req_father_pos_x <= pending_items[0].fpx;
            req_father_pos_y <= pending_items[0].fpy;
            req_father_pos_z <= pending_items[0].fpz;
            req_father_rot_x <= pending_items[0].frx;
            req_father_rot_y <= pending_items[0].fry;
            req_child_pos_x <= pending_items[0].cpx;
            req_child_pos_y <= pending_items[0].cpy;
            req_child_pos_z <= pending_items[0].cpz;
            req_child_rot_x <= pending_items[0].crx;
            req_child_rot_y <= pending_items[0].cry;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      joint_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_out_x, 32'h0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_kind !== e.kind)
               report_mismatch("kind", 32'(rsp_result_kind), 32'(e.kind));
            if (rsp_out_x !== e.x) report_mismatch("out_x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report_mismatch("out_y", rsp_out_y, e.y);
            if (rsp_out_z !== e.z) report_mismatch("out_z", rsp_out_z, e.z);
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         rsp_gap <= $urandom_range(1, 17) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_pivot(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      pivot_cfg[idx] = signed'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_block();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_pivot(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      write_pivot(pjr_pkg::CSR_PIVOT_X, px);
      write_pivot(pjr_pkg::CSR_PIVOT_Y, py);
      write_pivot(pjr_pkg::CSR_PIVOT_Z, pz);
   endtask

   initial begin
      joint_item_type it;
      pivot_cfg = '{0, 0, 0};
      rot_pivot = '{0, 0, 0};
      pivot_ang_x = 0; pivot_ang_y = 0; last_frx = 0; last_fry = 0;
      foreach (attached[i]) attached[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_pivot(32'h0001_0000, 32'hffff_8000, 32'h0002_0000);
      // pivot update before any attach, then attach at extremes
      queue_item(make_item(pjr_pkg::MODE_PIVOT, 3'd0));
      it = make_item(pjr_pkg::MODE_ATTACH, 3'd0);
      it.cpx = 32'h7fffffff; it.fpx = 32'h80000000;
      it.cpy = 32'h80000000; it.fpy = 32'h7fffffff;
      queue_item(it);
      it = make_item(pjr_pkg::MODE_MOVE, 3'd0);
      it.crx = 32'h7fffffff; it.cry = 32'h80000000;
      queue_item(it);
      it = make_item(pjr_pkg::MODE_ATTACH, 3'd7);
      it.crx = 32'h0001_921f; it.cry = 32'hfffe_6de1;
      queue_item(it);
      for (int k = 0; k < 6; k++) begin
         it = make_item(pjr_pkg::MODE_MOVE, 3'd7);
         it.crx = k * 51472; it.cry = -k * 60000;
         queue_item(it);
      end
      for (int k = 0; k < 4; k++) begin
         it = make_item(pjr_pkg::MODE_PIVOT, 3'd0);
         it.frx = k * 102944; it.fry = 32'h7fffffff - k;
         queue_item(it);
      end
      queue_item(make_item(pjr_pkg::MODE_NONE, 3'd2));
      queue_item(make_item(pjr_pkg::MODE_MOVE, 3'd0));
      drain_block();

      set_pivot(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      foreach (attached[i]) queue_item(make_item(pjr_pkg::MODE_ATTACH, 3'(i)));
      for (int k = 0; k < 4; k++) queue_item(make_item(k[1:0], 3'($urandom_range(0, 7))));
      drain_block();
      set_pivot(32'h0, 32'h0, 32'h0);
      for (int k = 0; k < 300; k++) begin
         it = make_item($urandom_range(0, 19) == 0 ? pjr_pkg::MODE_ATTACH
                        : ($urandom_range(0, 2) == 0 ? pjr_pkg::MODE_PIVOT
                                                     : pjr_pkg::MODE_MOVE),
                        3'($urandom_range(0, 7)));
         if ($urandom_range(0, 30) == 0) it.mode = pjr_pkg::MODE_NONE;
         queue_item(it);
      end
      drain_block();
      set_pivot(rand_q(), rand_q(), rand_q());
      for (int k = 0; k < 500; k++) begin
         it = make_item($urandom_range(0, 19) == 0 ? pjr_pkg::MODE_ATTACH
                        : ($urandom_range(0, 2) == 0 ? pjr_pkg::MODE_PIVOT
                                                     : pjr_pkg::MODE_MOVE),
                        3'($urandom_range(0, 7)));
         if ($urandom_range(0, 30) == 0) it.mode = pjr_pkg::MODE_NONE;
         queue_item(it);
      end
      drain_block();
      set_pivot(32'h80000000, 32'h7fffffff, 32'h80000000);
      quiet_phase = 1'b1;
      for (int k = 0; k < 260; k++)
         queue_item(make_item(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7))));
      drain_block();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
